// ===== design/tpgd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpgd_pkg
// shared widths, register indexes and version codes of the tape gap decoder
// ----------------------------------------------------------------------------
package tpgd_pkg;

    localparam int BYTE_W  = 8;
    localparam int ACC_W   = 24;
    localparam int GAP_W   = 25;
    localparam int VER_W   = 2;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 24;
    localparam int PHASE_W = 2;

    localparam logic [IDX_W-1:0] REG_TAP_VERSION    = 2'd0;
    localparam logic [IDX_W-1:0] REG_C16_MODE       = 2'd1;
    localparam logic [IDX_W-1:0] REG_ZERO_GAP_DELAY = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPEED_TUNING   = 2'd3;

    localparam logic [VER_W-1:0] VER_0 = 2'd0;
    localparam logic [VER_W-1:0] VER_1 = 2'd1;

    localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_B0   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_B1   = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_B2   = 2'd3;

    localparam logic [ACC_W-1:0]  ZERO_GAP_RESET    = 24'd20000;
    localparam logic [BYTE_W-1:0] SPEED_TUNE_RESET  = 8'd1;

    typedef logic [GAP_W-1:0] gap_t;

endpackage

// ===== design/tap_pulse_gap_decoder.sv =====
// ----------------------------------------------------------------------------
// tap_pulse_gap_decoder
// turns a forward stream of tape image bytes into pulse gap lengths in cycles
// ----------------------------------------------------------------------------
// One tape byte is taken per cycle while in_stall is low and decoded in a single
// pass into an output register. A nonzero byte gives byte*8 plus the speed tuning
// value; a zero byte gives the zero gap delay plus the speed tuning value (version 0
// without half-wave mode) or opens a long gap whose next three bytes, low byte
// first, form a 24-bit count (zero meaning the zero gap delay). In half-wave mode
// version 0 and 1 gaps go out twice, higher versions doubled. A gap sent twice
// holds the output register for two transfers, so the input is held until the
// second transfer goes out; bytes that give no result still wait while it is full.
module tap_pulse_gap_decoder
    import tpgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] tape_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [GAP_W-1:0]  gap_cycles,
    output logic              last_of_run
);

    logic [VER_W-1:0]   tap_version_reg;
    logic               c16_mode_reg;
    logic [ACC_W-1:0]   zero_gap_delay_reg;
    logic [BYTE_W-1:0]  speed_tuning_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [ACC_W-1:0]   accum_reg, accum_next;

    logic               valid_reg, valid_next;
    logic               twice_reg, twice_next;
    gap_t               gap_reg, gap_next;

    logic               in_xfer;
    logic               out_xfer;
    logic               emit;
    gap_t               raw_gap;
    gap_t               sent_gap;
    logic               send_twice;
    logic [ACC_W-1:0]   long_count;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_version_reg    <= VER_0;
            c16_mode_reg       <= 1'b0;
            zero_gap_delay_reg <= ZERO_GAP_RESET;
            speed_tuning_reg   <= SPEED_TUNE_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_TAP_VERSION:    tap_version_reg    <= cfg_data[VER_W-1:0];
                REG_C16_MODE:       c16_mode_reg       <= cfg_data[0];
                REG_ZERO_GAP_DELAY: zero_gap_delay_reg <= cfg_data[ACC_W-1:0];
                REG_SPEED_TUNING:   speed_tuning_reg   <= cfg_data[BYTE_W-1:0];
                default:            ;
            endcase
        end
    end

    assign out_xfer = valid_reg && !out_stall;
    assign in_stall = valid_reg && !(out_xfer && !twice_reg);
    assign in_xfer  = in_valid && !in_stall;

    assign long_count = {tape_byte, accum_reg[2*BYTE_W-1:0]};

    // decode
    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        emit       = 1'b0;
        raw_gap    = '0;
        case (phase_reg)
            PHASE_B0:
            begin
                accum_next = {{(ACC_W-BYTE_W){1'b0}}, tape_byte};
                phase_next = PHASE_B1;
            end
            PHASE_B1:
            begin
                accum_next = {{BYTE_W{1'b0}}, tape_byte, accum_reg[BYTE_W-1:0]};
                phase_next = PHASE_B2;
            end
            PHASE_B2:
            begin
                accum_next = '0;
                phase_next = PHASE_IDLE;
                emit       = 1'b1;
                raw_gap    = (long_count != '0) ? {1'b0, long_count}
                                                : {1'b0, zero_gap_delay_reg};
            end
            default:
            begin
                if (tape_byte != '0)
                begin
                    emit    = 1'b1;
                    raw_gap = {{(GAP_W-BYTE_W-3){1'b0}}, tape_byte, 3'b000}
                            + {{(GAP_W-BYTE_W){1'b0}}, speed_tuning_reg};
                end
                else if (tap_version_reg != VER_0 || c16_mode_reg)
                begin
                    accum_next = '0;
                    phase_next = PHASE_B0;
                end
                else
                begin
                    emit    = 1'b1;
                    raw_gap = {1'b0, zero_gap_delay_reg}
                            + {{(GAP_W-BYTE_W){1'b0}}, speed_tuning_reg};
                end
            end
        endcase
    end

    // half-wave handling
    assign send_twice = c16_mode_reg
                     && (tap_version_reg == VER_0 || tap_version_reg == VER_1);
    assign sent_gap   = (c16_mode_reg && !send_twice) ? {raw_gap[GAP_W-2:0], 1'b0}
                                                      : raw_gap;

    // output register
    always_comb
    begin
        valid_next = valid_reg;
        twice_next = twice_reg;
        gap_next   = gap_reg;
        if (out_xfer)
        begin
            if (twice_reg)
                twice_next = 1'b0;
            else
                valid_next = 1'b0;
        end
        if (in_xfer && emit)
        begin
            valid_next = 1'b1;
            twice_next = send_twice;
            gap_next   = sent_gap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_IDLE;
            accum_reg <= '0;
            valid_reg <= 1'b0;
            twice_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            twice_reg <= twice_next;
            if (in_xfer)
            begin
                phase_reg <= phase_next;
                accum_reg <= accum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gap_reg <= gap_next;
    end

    assign out_valid   = valid_reg;
    assign gap_cycles  = gap_reg;
    assign last_of_run = !twice_reg;

`ifndef SYNTHESIS
    a_twice_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        twice_reg |-> valid_reg)
        else $error("pending second half wave without a valid result");

    a_second_half: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && !last_of_run) |=> (out_valid && last_of_run
                                        && $stable(gap_cycles)))
        else $error("second half wave missing or changed");

    a_long_gap_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && phase_reg == PHASE_B2) |=> (valid_reg && phase_reg == PHASE_IDLE))
        else $error("third long gap byte gave no result");

    a_no_accept_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && valid_reg) |-> (out_xfer && !twice_reg))
        else $error("byte accepted while result register held");
`endif

endmodule
